// ===== sv/nadam_parameter_update_macros.svh =====
// ----------------------------------------------------------------------------
// Nadam parameter update: assertion macros
// Concurrent checks clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef NADAM_PARAMETER_UPDATE_MACROS_SVH
`define NADAM_PARAMETER_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every edge.
`define NADAM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("nadam check failed");
// Consequent holds in the same cycle as the antecedent.
`define NADAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nadam check failed");
// Consequent holds in the cycle after the antecedent.
`define NADAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nadam check failed");
`else
`define NADAM_ASSERT(lbl, cond)
`define NADAM_ASSERT_IMP(lbl, ante, cons)
`define NADAM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/nadam_pkg.sv =====
// ----------------------------------------------------------------------------
// Nadam parameter update: shared package
// Field widths, register indexes, sequencer states and saturation helpers.
// ----------------------------------------------------------------------------
package nadam_pkg;

  localparam int IDX_W     = 6;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register reset values (0.88441989 and 0.08381 in Q0.16).
  localparam logic [CFG_W-1:0] RST_BETA  = 16'd57961;
  localparam logic [CFG_W-1:0] RST_STEP  = 16'd5493;
  localparam logic [CFG_W-1:0] RST_FLOOR = 16'd1;

  localparam logic [32:0] POWER_ONE = 33'h1_0000_0000;
  localparam logic [16:0] BETA_ONE  = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA_FIRST  = 2'd0,
    CFG_BETA_SECOND = 2'd1,
    CFG_STEP_SIZE   = 2'd2,
    CFG_VAR_FLOOR   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_GRAD, ST_MOM, ST_DIV_MH, ST_DIV_GT, ST_DIV_VH,
    ST_SQRT, ST_NUM, ST_SCALE, ST_DIV_Q, ST_POS, ST_DONE
  } state_t;

  // Signed 32-bit value with a clip mark.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clip;
  } sclip_t;

  // Clip a wide signed value to signed 32 bits.
  function automatic sclip_t sat32(input logic signed [63:0] x);
    sclip_t r;
    if (x > 64'sd2147483647) begin
      r.value = 32'sh7FFF_FFFF;
      r.clip  = 1'b1;
    end else if (x < -64'sd2147483648) begin
      r.value = 32'sh8000_0000;
      r.clip  = 1'b1;
    end else begin
      r.value = x[31:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

  // Apply a sign to a magnitude quotient, limiting it to 2^31 and then to s32.
  function automatic sclip_t quot_to_s32(input logic [63:0] q, input logic neg);
    sclip_t      r;
    logic        over;
    logic [31:0] qs;
    over = (q > 64'h8000_0000);
    qs   = over ? 32'h8000_0000 : q[31:0];
    if (neg) begin
      r.value = signed'(~qs + 32'd1);
      r.clip  = over;
    end else begin
      r.value = qs[31] ? 32'sh7FFF_FFFF : signed'(qs);
      r.clip  = over | qs[31];
    end
    return r;
  endfunction

endpackage

// ===== sv/nadam_in_if.sv =====
// ----------------------------------------------------------------------------
// Nadam parameter update: input item channel
// Valid/ready channel carrying one load or gradient beat.
// ----------------------------------------------------------------------------
interface nadam_in_if;
  import nadam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;
  logic                     starts_iteration;

  modport source (output valid, func, index, value, starts_iteration, input ready);
  modport sink   (input valid, func, index, value, starts_iteration, output ready);
endinterface

// ===== sv/nadam_out_if.sv =====
// ----------------------------------------------------------------------------
// Nadam parameter update: result channel
// Valid/ready channel carrying one updated coordinate beat.
// ----------------------------------------------------------------------------
interface nadam_out_if;
  import nadam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         element;
  logic signed [DATA_W-1:0] new_position;
  logic                     saturated;

  modport source (output valid, element, new_position, saturated, input ready);
  modport sink   (input valid, element, new_position, saturated, output ready);
endinterface

// ===== sv/nadam_parameter_update.sv =====
// Flow: a load or out-of-range beat passes through READ and DONE; an update beat also
// runs four 64-step radix-2 divisions on one shared divider and a 32-step square root.
// A new beat is taken only in IDLE, once the previous result has entered the output
// register, so the block never works on two beats at once.
// Reset: registers return to their defaults, bias powers to one, all moments read as
// zero through per-entry valid bits; positions are undefined until loaded.
// ----------------------------------------------------------------------------
// Nadam parameter update
// Element-wise Nadam step over state held in two single-port-read memories.
// ----------------------------------------------------------------------------
`include "nadam_parameter_update_macros.svh"

module nadam_parameter_update #(
  parameter int DIMENSION     = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [nadam_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [nadam_pkg::CFG_W-1:0]     wr_data,
  nadam_in_if.sink                       item,
  nadam_out_if.source                    result
);
  import nadam_pkg::*;

  localparam int DEPTH = (DIMENSION < 64) ? DIMENSION : 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UP    = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int DN    = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [5:0] SQ_LAST  = 6'd31;

  // Control state
  state_t      state, state_next;
  logic [5:0]  cnt;
  logic [32:0] p1, p2;
  logic [15:0] beta_first, beta_second, step_size, variance_floor;
  logic [DEPTH-1:0] mom_vld;
  logic        out_valid;

  // Item and datapath registers
  logic                     func_r, start_r, in_range_r, flag_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [31:0]       val_r, m_old, m_r, mh_r, gt_r, num_r;
  logic [31:0]              v_old, v_r, gabs_r;
  logic [63:0]              gsq_raw, gdiv, q_r;
  logic [32:0]              d1_r, d2_r, root_r;
  logic signed [31:0]       res_pos;
  logic [IDX_W-1:0]         out_elem;
  logic signed [31:0]       out_pos;
  logic                     out_sat;

  // Shared divider and root unit registers
  logic [63:0] div_num, div_quo;
  logic [33:0] div_rem;
  logic [32:0] div_den;
  logic [63:0] sq_x, sq_r, sq_bit;

  // Memories: positions, and first/second moments packed in one word
  logic [31:0] pos_mem [DEPTH];
  logic [63:0] mom_mem [DEPTH];
  logic [31:0] pos_rd;
  logic [63:0] mom_rd;
  logic        accept, slot_free;
  logic        pos_we, mom_we;
  logic [31:0] pos_wd;
  logic [63:0] mom_wd;
  logic [AW-1:0] rd_addr, wr_addr;

  assign accept    = item.valid && item.ready;
  assign slot_free = !out_valid || result.ready;
  assign rd_addr   = AW'(item.index);
  assign wr_addr   = AW'(idx_r);

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wr_addr] <= pos_wd;
    if (accept) pos_rd <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mom_we) mom_mem[wr_addr] <= mom_wd;
    if (accept) mom_rd <= mom_mem[rd_addr];
  end

  // Moment and power arithmetic
  logic [16:0]        omb1, omb2;
  logic signed [16:0] b1_s;
  logic signed [17:0] omb1_s;
  logic signed [48:0] m_p0;
  logic signed [49:0] m_p1;
  logic signed [51:0] m_acc;
  logic signed [35:0] m_rnd;
  sclip_t             m_new;
  logic [31:0]        m_mag;
  logic [63:0]        gsq_sh, gsq_p;
  logic               gsq_over;
  logic [31:0]        gsq32;
  logic [47:0]        v_p0;
  logic [48:0]        v_p1, gg;
  logic [50:0]        v_acc;
  logic [31:0]        v_new;
  logic [48:0]        p1_prod, p2_prod;
  logic [32:0]        d1_raw, d2_raw;
  logic [31:0]        gabs;

  assign omb1     = BETA_ONE - {1'b0, beta_first};
  assign omb2     = BETA_ONE - {1'b0, beta_second};
  assign b1_s     = signed'({1'b0, beta_first});
  assign omb1_s   = signed'({1'b0, omb1});
  assign m_p0     = b1_s * m_old;
  assign m_p1     = omb1_s * val_r;
  assign m_acc    = 52'(m_p0) + 52'(m_p1) + 52'sd32768;
  assign m_rnd    = 36'(m_acc >>> 16);
  assign m_new    = sat32(64'(m_rnd));
  assign m_mag    = m_new.value[31] ? unsigned'(32'(-m_new.value)) : unsigned'(m_new.value);
  assign gsq_p    = gabs_r * gabs_r;
  assign gsq_sh   = gsq_raw >> FRACTION_BITS;
  assign gsq_over = |gsq_sh[63:32];
  assign gsq32    = gsq_over ? 32'hFFFF_FFFF : gsq_sh[31:0];
  assign v_p0     = beta_second * v_old;
  assign v_p1     = omb2 * gsq32;
  assign v_acc    = 51'(v_p0) + 51'(v_p1) + 51'd32768;
  assign v_new    = v_acc[47:16];
  assign gg       = gabs_r * omb1;
  assign p1_prod  = p1 * beta_first;
  assign p2_prod  = p2 * beta_second;
  assign d1_raw   = POWER_ONE - p1;
  assign d2_raw   = POWER_ONE - p2;
  assign gabs     = val_r[31] ? unsigned'(32'(-val_r)) : unsigned'(val_r);

  // One restoring division step per cycle
  logic [33:0] rem_sh, rem_nx;
  logic        div_ge;
  logic [63:0] quo_nx;
  assign rem_sh = {div_rem[32:0], div_num[63]};
  assign div_ge = rem_sh >= {1'b0, div_den};
  assign rem_nx = div_ge ? rem_sh - {1'b0, div_den} : rem_sh;
  assign quo_nx = {div_quo[62:0], div_ge};

  // One digit-by-digit root step per cycle
  logic [63:0] sq_trial, sq_x_nx, sq_r_nx;
  logic        sq_ge;
  assign sq_trial = sq_r + sq_bit;
  assign sq_ge    = sq_x >= sq_trial;
  assign sq_x_nx  = sq_ge ? sq_x - sq_trial : sq_x;
  assign sq_r_nx  = sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;

  // Division results, corrected variance and its floor
  sclip_t      div_s32_m, div_s32_g;
  logic        vh_over;
  logic [31:0] vh, fl, vv;
  assign div_s32_m = quot_to_s32(quo_nx, m_r[31]);
  assign div_s32_g = quot_to_s32(quo_nx, val_r[31]);
  assign vh_over   = |quo_nx[63:32];
  assign vh        = vh_over ? 32'hFFFF_FFFF : quo_nx[31:0];
  assign fl        = (variance_floor == 16'd0) ? 32'd1 : 32'(variance_floor);
  assign vv        = (vh > fl) ? vh : fl;

  // Numerator, scaled step and new position
  logic signed [48:0] n_p;
  logic signed [33:0] n_rnd;
  sclip_t             num;
  logic [31:0]        nmag;
  logic [47:0]        scaled;
  logic [63:0]        q_sh;
  logic signed [63:0] pos_diff;
  sclip_t             pos_new;
  assign n_p      = b1_s * mh_r;
  assign n_rnd    = 34'((50'(n_p) + 50'sd32768) >>> 16);
  assign num      = sat32(64'(n_rnd) + 64'(gt_r));
  assign nmag     = num_r[31] ? unsigned'(32'(-num_r)) : unsigned'(num_r);
  assign scaled   = step_size * nmag;
  assign q_sh     = (q_r << UP) >> DN;
  assign pos_diff = num_r[31] ? 64'(signed'(pos_rd)) + signed'(q_sh)
                              : 64'(signed'(pos_rd)) - signed'(q_sh);
  assign pos_new  = sat32(pos_diff);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_READ;
      ST_READ:   state_next = (in_range_r && func_r == FUNC_UPDATE) ? ST_GRAD : ST_DONE;
      ST_GRAD:   state_next = ST_MOM;
      ST_MOM:    state_next = ST_DIV_MH;
      ST_DIV_MH: if (cnt == DIV_LAST) state_next = ST_DIV_GT;
      ST_DIV_GT: if (cnt == DIV_LAST) state_next = ST_DIV_VH;
      ST_DIV_VH: if (cnt == DIV_LAST) state_next = ST_SQRT;
      ST_SQRT:   if (cnt == SQ_LAST) state_next = ST_NUM;
      ST_NUM:    state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DIV_Q;
      ST_DIV_Q:  if (cnt == DIV_LAST) state_next = ST_POS;
      ST_POS:    state_next = ST_DONE;
      ST_DONE:   if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshakes and memory writes
  always_comb begin
    item.ready          = (state == ST_IDLE);
    result.valid        = out_valid;
    result.element      = out_elem;
    result.new_position = out_pos;
    result.saturated    = out_sat;
    pos_we = 1'b0;
    pos_wd = pos_new.value;
    mom_we = 1'b0;
    mom_wd = {m_new.value, v_new};
    if (state == ST_READ && in_range_r && func_r == FUNC_LOAD) begin
      pos_we = 1'b1;
      pos_wd = val_r;
      mom_we = 1'b1;
      mom_wd = '0;
    end else if (state == ST_MOM) begin
      mom_we = 1'b1;
    end else if (state == ST_POS) begin
      pos_we = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cnt            <= '0;
      p1             <= POWER_ONE;
      p2             <= POWER_ONE;
      beta_first     <= RST_BETA;
      beta_second    <= RST_BETA;
      step_size      <= RST_STEP;
      variance_floor <= RST_FLOOR;
      mom_vld        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else cnt <= cnt + 6'd1;
      if (wr_en) begin
        unique case (cfg_index_t'(wr_index))
          CFG_BETA_FIRST:  beta_first     <= wr_data;
          CFG_BETA_SECOND: beta_second    <= wr_data;
          CFG_STEP_SIZE:   step_size      <= wr_data;
          CFG_VAR_FLOOR:   variance_floor <= wr_data;
          default:         ;
        endcase
      end
      if (mom_we) mom_vld[wr_addr] <= 1'b1;
      if (state == ST_READ && in_range_r) begin
        if (func_r == FUNC_LOAD && idx_r == '0) begin
          p1 <= POWER_ONE;
          p2 <= POWER_ONE;
        end else if (func_r == FUNC_UPDATE && start_r) begin
          p1 <= p1_prod[48:16];
          p2 <= p2_prod[48:16];
        end
      end
      if (state == ST_DONE && slot_free) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= item.func;
      idx_r      <= item.index;
      val_r      <= item.value;
      start_r    <= item.starts_iteration;
      in_range_r <= (32'(item.index) < DIMENSION);
      flag_r     <= 1'b0;
    end
    // Default division and root stepping
    div_rem <= rem_nx;
    div_quo <= quo_nx;
    div_num <= div_num << 1;
    sq_x    <= sq_x_nx;
    sq_r    <= sq_r_nx;
    sq_bit  <= sq_bit >> 2;
    unique case (state)
      ST_READ: begin
        res_pos <= in_range_r ? val_r : 32'sd0;
        m_old   <= mom_vld[wr_addr] ? signed'(mom_rd[63:32]) : 32'sd0;
        v_old   <= mom_vld[wr_addr] ? mom_rd[31:0] : 32'd0;
        gabs_r  <= gabs;
      end
      ST_GRAD: begin
        gsq_raw <= gsq_p;
        gdiv    <= 64'(gg) << 16;
        d1_r    <= (d1_raw == '0) ? POWER_ONE : d1_raw;
        d2_r    <= (d2_raw == '0) ? POWER_ONE : d2_raw;
      end
      ST_MOM: begin
        m_r     <= m_new.value;
        v_r     <= v_new;
        flag_r  <= flag_r | m_new.clip | gsq_over;
        div_num <= {m_mag, 32'd0};
        div_den <= d1_r;
        div_rem <= '0;
        div_quo <= '0;
      end
      ST_DIV_MH: if (cnt == DIV_LAST) begin
        mh_r    <= div_s32_m.value;
        flag_r  <= flag_r | div_s32_m.clip;
        div_num <= gdiv;
        div_den <= d1_r;
        div_rem <= '0;
        div_quo <= '0;
      end
      ST_DIV_GT: if (cnt == DIV_LAST) begin
        gt_r    <= div_s32_g.value;
        flag_r  <= flag_r | div_s32_g.clip;
        div_num <= {v_r, 32'd0};
        div_den <= d2_r;
        div_rem <= '0;
        div_quo <= '0;
      end
      ST_DIV_VH: if (cnt == DIV_LAST) begin
        flag_r <= flag_r | vh_over;
        sq_x   <= 64'(vv) << FRACTION_BITS;
        sq_r   <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: if (cnt == SQ_LAST) root_r <= sq_r_nx[32:0];
      ST_NUM: begin
        num_r  <= num.value;
        flag_r <= flag_r | num.clip;
      end
      ST_SCALE: begin
        div_num <= 64'(scaled);
        div_den <= root_r;
        div_rem <= '0;
        div_quo <= '0;
      end
      ST_DIV_Q: if (cnt == DIV_LAST) q_r <= quo_nx;
      ST_POS: begin
        res_pos <= pos_new.value;
        flag_r  <= flag_r | pos_new.clip;
      end
      ST_DONE: if (slot_free) begin
        out_elem <= idx_r;
        out_pos  <= res_pos;
        out_sat  <= flag_r;
      end
      default: ;
    endcase
  end

  // The divider is busy in any of the four division states.
  logic in_div;
  assign in_div = state == ST_DIV_MH || state == ST_DIV_GT || state == ST_DIV_VH ||
                  state == ST_DIV_Q;

  // Checks
  `NADAM_ASSERT(a_power_bound, p1 <= POWER_ONE && p2 <= POWER_ONE)
  `NADAM_ASSERT_IMP(a_den_nonzero, in_div, div_den != '0)
  `NADAM_ASSERT_NEXT(a_result_issued, state == ST_DONE && slot_free, out_valid && state == ST_IDLE)

endmodule

// ===== bench/nadam_parameter_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nadam parameter update testbench
// Drives load and gradient beats with random idling on both channels. A local
// fixed-point model of the Nadam step predicts each coordinate, and every
// result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module nadam_parameter_update_tb;
  import nadam_pkg::*;

  localparam int DIM = 64;

  typedef struct packed {
    logic [IDX_W-1:0]         element;
    logic signed [DATA_W-1:0] new_position;
    logic                     saturated;
  } coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;

  nadam_in_if  item ();
  nadam_out_if result ();

  nadam_parameter_update dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .item(item.sink), .result(result.source)
  );

  always #6 clk = ~clk;

  // Model state.
  logic [15:0] b1_reg, b2_reg, step_reg, floor_reg;
  logic [31:0] pos_mem [DIM];
  logic [31:0] m_mem [DIM];
  logic [31:0] v_mem [DIM];
  logic [63:0] pow1, pow2;

  coord_t      coord_q[$];
  int          mismatches = 0;
  bit          idle_on = 1'b1;

  // Clip to signed 32 bits.
  function automatic longint clip32(input longint x, inout bit f);
    if (x > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
    if (x < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
    return x;
  endfunction

  // Round half up at 2^-16.
  function automatic longint rnd16(input longint x);
    return (x + 32768) >>> 16;
  endfunction

  // sign(a) * trunc(|a| * scale / d), clipped.
  function automatic longint sdiv(input longint a, input logic [63:0] scale,
                                  input logic [63:0] d, inout bit f);
    logic [127:0] q;
    logic [63:0]  mag;
    mag = a < 0 ? -a : a;
    q = ({64'd0, mag} * scale) / d;
    if (q > 128'h8000_0000) begin f = 1; q = 128'h8000_0000; end
    return clip32(a < 0 ? -longint'(q[63:0]) : longint'(q[63:0]), f);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin x -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // Predict one beat's result and advance the model state.
  function automatic coord_t nadam_predict(input func_t fn, input logic [5:0] ix,
                                           input logic [31:0] val, input bit adv);
    coord_t c;
    bit f;
    longint g, m, mh, gt, num, pos, res;
    logic [63:0] omb1, omb2, d1, d2, gmag, gsq, v, vh, fl, vv, rt, nmag;
    logic [127:0] t;
    f = 0;
    g = longint'(signed'(val));
    if (fn == FUNC_LOAD) begin
      pos_mem[ix] = val; m_mem[ix] = 0; v_mem[ix] = 0;
      if (ix == 0) begin pow1 = 64'h1_0000_0000; pow2 = 64'h1_0000_0000; end
      res = g;
    end else begin
      omb1 = 65536 - b1_reg;
      omb2 = 65536 - b2_reg;
      if (adv) begin
        pow1 = (pow1 * b1_reg) >> 16;
        pow2 = (pow2 * b2_reg) >> 16;
      end
      d1 = 64'h1_0000_0000 - pow1;
      d2 = 64'h1_0000_0000 - pow2;
      if (d1 == 0) d1 = 64'h1_0000_0000;
      if (d2 == 0) d2 = 64'h1_0000_0000;
      m = longint'(signed'(m_mem[ix]));
      m = clip32(rnd16(longint'(b1_reg) * m + longint'(omb1) * g), f);
      m_mem[ix] = m[31:0];
      gmag = g < 0 ? -g : g;
      gsq = (gmag * gmag) >> 16;
      if (gsq > 64'hFFFF_FFFF) begin f = 1; gsq = 64'hFFFF_FFFF; end
      v = ((b2_reg * {32'd0, v_mem[ix]} + omb2 * gsq + 32768) >> 16) & 64'hFFFF_FFFF;
      v_mem[ix] = v[31:0];
      mh = sdiv(m, 64'h1_0000_0000, d1, f);
      gt = sdiv(g, omb1 << 16, d1, f);
      t = ({64'd0, v} << 32) / d2;
      vh = t > 128'hFFFF_FFFF ? 64'hFFFF_FFFF : t[63:0];
      if (t > 128'hFFFF_FFFF) f = 1;
      num = clip32(rnd16(longint'(b1_reg) * mh) + gt, f);
      fl = floor_reg == 0 ? 1 : floor_reg;
      vv = vh > fl ? vh : fl;
      rt = root64(vv << 16);
      nmag = num < 0 ? -num : num;
      t = ({64'd0, nmag} * step_reg) / rt;
      pos = longint'(signed'(pos_mem[ix]));
      res = clip32(pos - (num < 0 ? -longint'(t[63:0]) : longint'(t[63:0])), f);
      pos_mem[ix] = res[31:0];
    end
    c.element = ix;
    c.new_position = res[31:0];
    c.saturated = f;
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  // Send one beat and record its prediction.
  task automatic send_beat(input func_t fn, input logic [5:0] ix, input logic [31:0] val,
                           input bit adv);
    idle_burst();
    item.valid <= 1'b1;
    item.func <= fn;
    item.index <= ix;
    item.value <= val;
    item.starts_iteration <= adv;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    coord_q.push_back(nadam_predict(fn, ix, val, adv));
    @(negedge clk);
    item.valid <= 1'b0;
    // The block stays busy after acceptance, so the next beat waits here.
    @(negedge clk);
  endtask

  task automatic drain();
    while (coord_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t r, input logic [15:0] d);
    wr_en <= 1'b1; wr_index <= r; wr_data <= d;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
    case (r)
      CFG_BETA_FIRST:  b1_reg = d;
      CFG_BETA_SECOND: b2_reg = d;
      CFG_STEP_SIZE:   step_reg = d;
      default:         floor_reg = d;
    endcase
  endtask

  // Receiver stalls and result checks.
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= !(idle_on && $urandom_range(0, 4) == 0);
  end

  always @(posedge clk) begin
    coord_t exp_c;
    if (!rst && result.valid && result.ready) begin
      if (coord_q.size() == 0) report_mismatch("result beat with nothing expected");
      else begin
        exp_c = coord_q.pop_front();
        if (result.element !== exp_c.element)
          report_mismatch($sformatf("element %0d, want %0d", result.element, exp_c.element));
        if (result.new_position !== exp_c.new_position)
          report_mismatch($sformatf("element %0d position %h, want %h", exp_c.element,
                                    result.new_position, exp_c.new_position));
        if (result.saturated !== exp_c.saturated)
          report_mismatch($sformatf("element %0d saturated %b, want %b", exp_c.element,
                                    result.saturated, exp_c.saturated));
      end
    end
  end

  task automatic load_all();
    for (int i = 0; i < DIM; i++)
      send_beat(FUNC_LOAD, 6'(i), $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Directed extremes: edge values, first update with no bias power yet, big gradients.
  task automatic test_directed();
    send_beat(FUNC_LOAD, 6'd0, 32'h7FFF_FFFF, 1'b1);
    send_beat(FUNC_LOAD, 6'd63, 32'h8000_0000, 1'b0);
    send_beat(FUNC_LOAD, 6'd1, 32'h0001_0000, 1'b0);
    send_beat(FUNC_UPDATE, 6'd1, 32'h0000_1000, 1'b0);
    send_beat(FUNC_UPDATE, 6'd0, 32'h8000_0000, 1'b1);
    send_beat(FUNC_UPDATE, 6'd63, 32'h7FFF_FFFF, 1'b0);
    send_beat(FUNC_UPDATE, 6'd1, 32'h0, 1'b1);
    send_beat(FUNC_UPDATE, 6'd1, 32'hFFFF_FFFF, 1'b0);
    send_beat(FUNC_UPDATE, 6'd0, 32'h7FFF_FFFF, 1'b1);
    send_beat(FUNC_UPDATE, 6'd63, 32'h8000_0000, 1'b1);
    drain();
  endtask

  // Well-formed iterations: one start beat, then a sweep of gradients.
  task automatic test_iterations(input int iters, input int width);
    for (int it = 0; it < iters; it++) begin
      for (int k = 0; k < width; k++) begin
        logic [31:0] g;
        case ($urandom_range(0, 3))
          0: g = $urandom;
          1: g = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
          default: g = $urandom_range(0, 32'h1FFF) - 32'h1000;
        endcase
        send_beat(FUNC_UPDATE, 6'($urandom_range(0, width - 1)), g, k == 0);
      end
      if ($urandom_range(0, 9) == 0)
        send_beat(FUNC_LOAD, 6'($urandom_range(0, DIM - 1)), $urandom, 1'b0);
    end
  endtask

  task automatic test_config(input logic [15:0] b1, input logic [15:0] b2,
                             input logic [15:0] st, input logic [15:0] fl);
    drain();
    write_reg(CFG_BETA_FIRST, b1);
    write_reg(CFG_BETA_SECOND, b2);
    write_reg(CFG_STEP_SIZE, st);
    write_reg(CFG_VAR_FLOOR, fl);
    load_all();
  endtask

  initial begin
    b1_reg = RST_BETA; b2_reg = RST_BETA; step_reg = RST_STEP; floor_reg = RST_FLOOR;
    pow1 = 64'h1_0000_0000; pow2 = 64'h1_0000_0000;
    item.valid = 1'b0; item.func = FUNC_LOAD; item.index = '0; item.value = '0;
    item.starts_iteration = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    load_all();
    test_iterations(6, 16);
    test_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_iterations(3, 32);
    test_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    test_iterations(2, 32);
    test_config(16'h8000, 16'hF000, 16'h4000, 16'h0100);
    test_iterations(4, 64);
    test_config(RST_BETA, RST_BETA, RST_STEP, RST_FLOOR);
    test_iterations(8, 48);
    drain();
    idle_on = 1'b0;
    test_iterations(3, 64);
    drain();
    repeat (320) @(negedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
